>>> hdl/sird_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sird_pkg
// Shared types and constants for the signed integer to radix digits block.
// ---------------------------------------------------------------------------
package sird_pkg;

  // Parameter defaults
  localparam int unsigned MAX_RADIX_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_SYM = 16;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HIGH = 2'd2;

  // Register reset values
  localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
  localparam logic [CFG_W-1:0]   SYM_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]   SYM_HIGH_RST = 64'h6665646362613938;

  // Reserved characters
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CONV,
    ST_SIGN,
    ST_DIGIT,
    ST_ERR
  } sird_state_e;

  // Control for the digit row
  typedef struct packed {
    logic clear;  // zero all digit cells
    logic step;   // double the row and add cin
    logic cin;    // magnitude bit entering at digit 0
  } sird_row_ctrl_t;

endpackage

>>> hdl/sird_digit_row.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sird_digit_row
// Row of radix-r digit cells; each step doubles the held number and adds one
// bit, with the inter-cell carries resolved as one generate/propagate add.
// ---------------------------------------------------------------------------
module sird_digit_row #(
  parameter int unsigned VALUE_BITS = sird_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  sird_pkg::sird_row_ctrl_t         ctrl_i,
  input  logic [sird_pkg::RADIX_W-1:0]     radix_i,
  input  logic [$clog2(VALUE_BITS)-1:0]    rd_idx_i,
  output logic [sird_pkg::DIGIT_W-1:0]     digit_o,
  output logic [VALUE_BITS:0]              carry_o
);

  localparam int unsigned DW = sird_pkg::DIGIT_W;
  localparam int unsigned RW = sird_pkg::RADIX_W;

  logic [DW-1:0]     dig_q [VALUE_BITS];
  logic [DW-1:0]     dig_d [VALUE_BITS];
  logic [RW-1:0]     two_d [VALUE_BITS];
  logic [RW-1:0]     sum_d [VALUE_BITS];
  logic [VALUE_BITS-1:0] gen, prp;
  logic [VALUE_BITS:0]   gp_a, gp_b, gp_sum, carry;
  logic [RW-1:0]     radix_m1;

  assign radix_m1 = radix_i - RW'(1);

  // cell generates when 2d >= r, propagates when 2d == r-1
  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      two_d[i] = {dig_q[i], 1'b0};
      gen[i]   = (two_d[i] >= radix_i);
      prp[i]   = (two_d[i] == radix_m1);
    end
  end

  assign gp_a   = {1'b0, gen | prp};
  assign gp_b   = {1'b0, gen};
  assign gp_sum = gp_a + gp_b + {{VALUE_BITS{1'b0}}, ctrl_i.cin};
  assign carry  = gp_sum ^ gp_a ^ gp_b;   // carry into each cell, [0] = cin

  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      sum_d[i] = two_d[i] + {{(RW-1){1'b0}}, carry[i]};
      dig_d[i] = carry[i+1] ? DW'(sum_d[i] - radix_i) : DW'(sum_d[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      for (int i = 0; i < VALUE_BITS; i++) dig_q[i] <= '0;
    end else if (ctrl_i.step) begin
      for (int i = 0; i < VALUE_BITS; i++) dig_q[i] <= dig_d[i];
    end
  end

  assign digit_o = dig_q[rd_idx_i];
  assign carry_o = carry;

endmodule

>>> hdl/signed_integer_to_radix_digits_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_integer_to_radix_digits_top
// Signed integer to radix text, one symbol byte per output beat.
// ---------------------------------------------------------------------------
// Each input beat carries a signed VALUE_BITS-bit value; the block answers
// with its text in the configured radix, most significant symbol first, a
// minus sign ahead of negative values, tlast on the final beat. A radix
// outside 2..MAX_RADIX, a used symbol of zero, '+' or '-', or a repeated used
// symbol gives one error beat instead (tdata 0, tlast 1, tuser 1). Per value,
// the table is checked first, then the magnitude enters the digit row one bit
// per cycle, MSB first (the row doubles and adds in radix r), then the sign
// and digit beats go out as the sink takes them, and the block returns to
// idle, where the next value is taken. A failed check goes straight to the
// error beat. A new value is taken once the last beat of the previous one
// sits in the output register, even if the sink has not taken it. Registers
// are written through cfg_we_i/cfg_idx_i/cfg_data_i (0 radix, 1 symbols
// 0..7, 2 symbols 8..15, lowest byte first); the user must write them only
// while the block idles, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
module signed_integer_to_radix_digits_top #(
  parameter int unsigned MAX_RADIX  = sird_pkg::MAX_RADIX_DEF,
  parameter int unsigned VALUE_BITS = sird_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // [VALUE_BITS-1:0] value
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sird_pkg::CHAR_W-1:0]        m_axis_tdata,  // [7:0] character
  output logic                               m_axis_tlast,  // last
  output logic [0:0]                         m_axis_tuser,  // [0] bad_table
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [sird_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sird_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned CW    = sird_pkg::CHAR_W;
  localparam int unsigned RW    = sird_pkg::RADIX_W;
  localparam int unsigned DW    = sird_pkg::DIGIT_W;
  localparam int unsigned NS    = sird_pkg::NUM_SYM;
  localparam int unsigned IDX_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam int unsigned BIT_W = $clog2(VALUE_BITS);

  // configuration
  logic [RW-1:0]             radix_q;
  logic [sird_pkg::CFG_W-1:0] sym_lo_q, sym_hi_q;

  // control
  sird_pkg::sird_state_e     state_q, state_d;
  logic [VALUE_BITS-1:0]     mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic [BIT_W-1:0]          bit_q, bit_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  // output register
  logic                      ovld_q;
  logic [CW-1:0]             ochar_q;
  logic                      olast_q, obad_q;
  logic                      out_load;
  logic [CW-1:0]             ochar_d;
  logic                      olast_d, obad_d;
  logic                      slot_free;

  // digit row
  sird_pkg::sird_row_ctrl_t  row_ctrl;
  logic [DW-1:0]             row_digit;
  logic [VALUE_BITS:0]       row_carry;

  // symbol table and its check
  logic [CW-1:0]             sym [NS];
  logic                      table_ok;
  logic [VALUE_BITS-1:0]     in_value;

  assign in_value = s_axis_tdata[VALUE_BITS-1:0];

  always_comb begin
    for (int i = 0; i < NS/2; i++) begin
      sym[i]        = sym_lo_q[i*CW +: CW];
      sym[i + NS/2] = sym_hi_q[i*CW +: CW];
    end
  end

  // pairwise checks are independent; j used implies every i < j used
  always_comb begin
    table_ok = (radix_q >= RW'(2)) && (radix_q <= RW'(MAX_RADIX));
    for (int i = 0; i < NS; i++) begin
      if (RW'(i) < radix_q) begin
        if (sym[i] == sird_pkg::CHAR_NUL || sym[i] == sird_pkg::CHAR_PLUS ||
            sym[i] == sird_pkg::CHAR_MINUS) begin
          table_ok = 1'b0;
        end
      end
      for (int j = i + 1; j < NS; j++) begin
        if (RW'(j) < radix_q && sym[i] == sym[j]) begin
          table_ok = 1'b0;
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= sird_pkg::RADIX_RST;
      sym_lo_q <= sird_pkg::SYM_LOW_RST;
      sym_hi_q <= sird_pkg::SYM_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sird_pkg::REG_RADIX:    radix_q  <= cfg_data_i[RW-1:0];
        sird_pkg::REG_SYM_LOW:  sym_lo_q <= cfg_data_i;
        sird_pkg::REG_SYM_HIGH: sym_hi_q <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign slot_free = !ovld_q || m_axis_tready;

  // next state and outputs
  always_comb begin
    state_d       = state_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    bit_d         = bit_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    ochar_d       = sird_pkg::CHAR_NUL;
    olast_d       = 1'b0;
    obad_d        = 1'b0;
    row_ctrl      = '0;
    row_ctrl.cin  = mag_q[VALUE_BITS-1];

    case (state_q)
      sird_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          neg_d   = in_value[VALUE_BITS-1];
          // unsigned negation, so the most negative value is exact
          mag_d   = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
          state_d = sird_pkg::ST_CHECK;
        end
      end
      sird_pkg::ST_CHECK: begin
        if (table_ok) begin
          row_ctrl.clear = 1'b1;
          cnt_d          = CNT_W'(1);
          bit_d          = '0;
          state_d        = sird_pkg::ST_CONV;
        end else begin
          state_d = sird_pkg::ST_ERR;
        end
      end
      sird_pkg::ST_CONV: begin
        row_ctrl.step = 1'b1;
        mag_d         = {mag_q[VALUE_BITS-2:0], 1'b0};
        bit_d         = bit_q + BIT_W'(1);
        // carry out of the top used digit widens the number
        if (row_carry[cnt_q] && cnt_q != CNT_W'(VALUE_BITS)) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (bit_q == BIT_W'(VALUE_BITS - 1)) begin
          state_d = neg_q ? sird_pkg::ST_SIGN : sird_pkg::ST_DIGIT;
        end
      end
      sird_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_load = 1'b1;
          ochar_d  = sird_pkg::CHAR_MINUS;
          state_d  = sird_pkg::ST_DIGIT;
        end
      end
      sird_pkg::ST_DIGIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          ochar_d  = sym[row_digit];
          olast_d  = (cnt_q == CNT_W'(1));
          cnt_d    = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = sird_pkg::ST_IDLE;
          end
        end
      end
      sird_pkg::ST_ERR: begin
        if (slot_free) begin
          out_load = 1'b1;
          ochar_d  = sird_pkg::CHAR_NUL;
          olast_d  = 1'b1;
          obad_d   = 1'b1;
          state_d  = sird_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sird_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sird_pkg::ST_IDLE;
      neg_q   <= 1'b0;
      bit_q   <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        ovld_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    if (out_load) begin
      ochar_q <= ochar_d;
      olast_q <= olast_d;
      obad_q  <= obad_d;
    end
  end

  sird_digit_row #(
    .VALUE_BITS (VALUE_BITS)
  ) u_row (
    .clk_i    (clk_i),
    .ctrl_i   (row_ctrl),
    .radix_i  (radix_q),
    .rd_idx_i (IDX_W'(cnt_q - CNT_W'(1))),
    .digit_o  (row_digit),
    .carry_o  (row_carry)
  );

  assign m_axis_tvalid   = ovld_q;
  assign m_axis_tdata    = ochar_q;
  assign m_axis_tlast    = olast_q;
  assign m_axis_tuser[0] = obad_q;

endmodule

>>> hdl/sird_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sird_checker
// Port-level checks on the output stream, bound to the top level.
// ---------------------------------------------------------------------------
module sird_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sird_pkg::CHAR_W-1:0]     m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [0:0]                      m_axis_tuser
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // error beat is a zero, final beat
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast &&
      m_axis_tdata == sird_pkg::CHAR_NUL)
    else $error("malformed error beat");

  // good beats never carry zero or '+'
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata != sird_pkg::CHAR_NUL && m_axis_tdata != sird_pkg::CHAR_PLUS)
    else $error("forbidden character on output");

  // a minus sign is never the final beat
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata == sird_pkg::CHAR_MINUS |->
      !m_axis_tlast)
    else $error("sign beat marked last");

endmodule

bind signed_integer_to_radix_digits_top sird_checker u_sird_checker (.*);
